[src/assert_macros.svh]
// Assertion macros shared by the RTL of the priority queue block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[src/dpof_pkg.sv]
// Package for the dual priority overwrite FIFO: operation codes, FSM type
// and default sizes. Depends on nothing.
`default_nettype none

package dpof_pkg;

  // Default sizes
  localparam int SENSOR_DEPTH_DEF  = 64;
  localparam int EVENT_DEPTH_DEF   = 16;
  localparam int PAYLOAD_WIDTH_DEF = 64;

  localparam int FUNC_W  = 2;
  localparam int COUNT_W = 32;

  // Operation codes carried on func
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Control FSM
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

[src/dpof_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module dpof_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/dual_priority_overwrite_fifo.sv]
// Top level of the dual priority overwrite FIFO: two ring buffers in RAM,
// pointers, drop counters and result register. Depends on dpof_pkg,
// dpof_ram and assert_macros.svh.
//
// Two ring buffers, sensor and event, each holding up to depth minus one
// records in a synchronous RAM. A push to a full queue overwrites its oldest
// record and bumps that queue's saturating drop counter. A pop serves the
// event queue first, then the sensor queue. A clear resets pointers and
// counters only; RAM contents are left as they are. One operation is in
// flight at a time: push, clear and unused codes load the result register
// when taken; a pop passes through ST_READ while the registered RAM read
// port fetches the record. A new operation is taken in the same cycle its
// predecessor's result is transferred out. sensor_drops and event_drops
// show the counters, which only change when a new operation is taken.
`default_nettype none
`include "assert_macros.svh"

module dual_priority_overwrite_fifo #(
  parameter int SENSOR_DEPTH  = dpof_pkg::SENSOR_DEPTH_DEF,
  parameter int EVENT_DEPTH   = dpof_pkg::EVENT_DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = dpof_pkg::PAYLOAD_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Operation channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [dpof_pkg::FUNC_W-1:0]  func,
  input  wire logic                         in_is_sensor,
  input  wire logic [PAYLOAD_WIDTH-1:0]     in_payload,
  // Result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              got_record,
  output logic                              out_is_sensor,
  output logic      [PAYLOAD_WIDTH-1:0]     out_payload,
  output logic                              overwrote_oldest,
  output logic      [dpof_pkg::COUNT_W-1:0] sensor_drops,
  output logic      [dpof_pkg::COUNT_W-1:0] event_drops
);

  localparam int SPW = $clog2(SENSOR_DEPTH);
  localparam int EPW = $clog2(EVENT_DEPTH);
  localparam logic [SPW-1:0] S_LAST = SPW'(SENSOR_DEPTH - 1);
  localparam logic [EPW-1:0] E_LAST = EPW'(EVENT_DEPTH - 1);

  dpof_pkg::state_t state, state_next;

  logic [SPW-1:0] srd, swr;
  logic [EPW-1:0] erd, ewr;
  logic [dpof_pkg::COUNT_W-1:0] s_cnt, e_cnt;

  // Pop bookkeeping held across the RAM read
  logic pop_hit, pop_sensor;

  logic accept, is_push, is_pop, is_clear;
  logic [SPW-1:0] s_wr_inc, s_rd_inc;
  logic [EPW-1:0] e_wr_inc, e_rd_inc;
  logic s_full, e_full, s_empty, e_empty;
  logic s_we, e_we, s_re, e_re;
  logic [PAYLOAD_WIDTH-1:0] s_rdata, e_rdata;
  logic res_load;

  // Pointer arithmetic with wrap at depth
  always_comb begin
    s_wr_inc = (swr == S_LAST) ? '0 : swr + 1'b1;
    s_rd_inc = (srd == S_LAST) ? '0 : srd + 1'b1;
    e_wr_inc = (ewr == E_LAST) ? '0 : ewr + 1'b1;
    e_rd_inc = (erd == E_LAST) ? '0 : erd + 1'b1;
    s_full   = (s_wr_inc == srd);
    e_full   = (e_wr_inc == erd);
    s_empty  = (srd == swr);
    e_empty  = (erd == ewr);
  end

  // Operation decode
  assign accept   = in_valid && in_ready;
  assign is_push  = (func == dpof_pkg::FUNC_PUSH);
  assign is_pop   = (func == dpof_pkg::FUNC_POP);
  assign is_clear = (func == dpof_pkg::FUNC_CLEAR);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dpof_pkg::ST_IDLE: begin
        if (accept && is_pop) begin
          state_next = dpof_pkg::ST_READ;
        end
      end
      dpof_pkg::ST_READ: begin
        state_next = dpof_pkg::ST_IDLE;
      end
      default: begin
        state_next = dpof_pkg::ST_IDLE;
      end
    endcase
  end

  // FSM outputs: handshake and RAM strobes
  always_comb begin
    in_ready = 1'b0;
    res_load = 1'b0;
    case (state)
      dpof_pkg::ST_IDLE: begin
        in_ready = !out_valid || out_ready;
        res_load = accept && !is_pop;
      end
      dpof_pkg::ST_READ: begin
        res_load = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    s_we = accept && is_push && in_is_sensor;
    e_we = accept && is_push && !in_is_sensor;
    e_re = accept && is_pop && !e_empty;
    s_re = accept && is_pop && e_empty && !s_empty;
  end

  // Only one operation is ever in flight, so a read never meets a write
  // to the same entry in one cycle.
  dpof_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (SENSOR_DEPTH)
  ) u_sensor_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (swr),
    .wdata (in_payload),
    .re    (s_re),
    .raddr (srd),
    .rdata (s_rdata)
  );

  dpof_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (EVENT_DEPTH)
  ) u_event_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (ewr),
    .wdata (in_payload),
    .re    (e_re),
    .raddr (erd),
    .rdata (e_rdata)
  );

  // Control state: FSM, pointers, drop counters, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dpof_pkg::ST_IDLE;
      srd       <= '0;
      swr       <= '0;
      erd       <= '0;
      ewr       <= '0;
      s_cnt     <= '0;
      e_cnt     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (func)
          dpof_pkg::FUNC_PUSH: begin
            if (in_is_sensor) begin
              swr <= s_wr_inc;
              if (s_full) begin
                srd <= s_rd_inc;
                if (s_cnt != '1) begin
                  s_cnt <= s_cnt + 1'b1;
                end
              end
            end else begin
              ewr <= e_wr_inc;
              if (e_full) begin
                erd <= e_rd_inc;
                if (e_cnt != '1) begin
                  e_cnt <= e_cnt + 1'b1;
                end
              end
            end
          end
          dpof_pkg::FUNC_POP: begin
            if (!e_empty) begin
              erd <= e_rd_inc;
            end else if (!s_empty) begin
              srd <= s_rd_inc;
            end
          end
          dpof_pkg::FUNC_CLEAR: begin
            srd   <= '0;
            swr   <= '0;
            erd   <= '0;
            ewr   <= '0;
            s_cnt <= '0;
            e_cnt <= '0;
          end
          default: begin
            // unused code: no state change
          end
        endcase
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pop_hit    <= !e_empty || !s_empty;
      pop_sensor <= e_empty;
    end
    if (res_load) begin
      if (state == dpof_pkg::ST_READ) begin
        got_record       <= pop_hit;
        out_is_sensor    <= pop_hit && pop_sensor;
        out_payload      <= !pop_hit ? '0 : (pop_sensor ? s_rdata : e_rdata);
        overwrote_oldest <= 1'b0;
      end else begin
        got_record       <= 1'b0;
        out_is_sensor    <= 1'b0;
        out_payload      <= '0;
        overwrote_oldest <= is_push && (in_is_sensor ? s_full : e_full);
      end
    end
  end

  // Counters move only when a new operation is taken, so the live values
  // match the pending result.
  assign sensor_drops = s_cnt;
  assign event_drops  = e_cnt;

  // Checks
  `ASSERT_IMPL(a_read_no_result, clk, rst, state == dpof_pkg::ST_READ, !out_valid && !in_ready)
  `ASSERT_NEXT(a_pop_to_read, clk, rst, accept && is_pop, state == dpof_pkg::ST_READ)
  `ASSERT_IMPL(a_empty_pop_zero, clk, rst, out_valid && !got_record, out_payload == '0 && !out_is_sensor)
  `ASSERT_IMPL(a_pop_no_overwrite, clk, rst, out_valid && got_record, !overwrote_oldest)
  `ASSERT_NEXT(a_drops_monotonic, clk, rst, accept && !is_clear, s_cnt >= $past(s_cnt) && e_cnt >= $past(e_cnt))

endmodule

`default_nettype wire
